/* design/alfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package alfb_pkg;

  // String geometry
  localparam int NUM_LEDS     = 64;
  localparam int RESET_SLOTS  = 41;
  localparam int BITS_PER_LED = 24;
  localparam int DATA_END     = RESET_SLOTS + BITS_PER_LED * NUM_LEDS;
  localparam int TOTAL_SLOTS  = 2 * RESET_SLOTS + BITS_PER_LED * NUM_LEDS;

  localparam int IDX_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int SLOT_W = $clog2(TOTAL_SLOTS);

  // Index mod NUM_LEDS by reciprocal multiply (exact for 16-bit indexes)
  localparam int          RECIP_SHIFT = 16 + $clog2(NUM_LEDS);
  localparam logic [16:0] RECIP_MULT  =
    17'((2 ** RECIP_SHIFT + NUM_LEDS - 1) / NUM_LEDS);

  // x / 3 for x below 2^17
  localparam logic [16:0] DIV3_MULT  = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // Register reset values
  localparam logic [7:0]  MULT_RESET   = 8'd1;
  localparam logic [7:0]  DIV_RESET    = 8'd1;
  localparam logic [15:0] PERIOD_RESET = 16'd104;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_WRITE_ONE = 3'd0,
    OP_WRITE_ALL = 3'd1,
    OP_READ_ONE  = 3'd2,
    OP_LATCH     = 3'd3,
    OP_START     = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } cmd_t;

endpackage

`default_nettype wire

/* design/alfb_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module alfb_front import alfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        cmd_push,
  output cmd_t        cmd_data,
  input  logic        cmd_full
);

  logic        stage_valid;
  op_t         stage_op;
  logic [15:0] stage_index;
  logic [15:0] stage_quot;
  logic [7:0]  stage_red;
  logic [7:0]  stage_green;
  logic [7:0]  stage_blue;

  logic        accept;
  logic        op_known;
  logic [32:0] recip_prod;
  logic [31:0] quot_scaled;
  logic [15:0] led_rem;

  // Beat taken unless the stage is holding a command the queue cannot take
  assign busy     = stage_valid && cmd_full;
  assign accept   = start && !busy;
  assign cmd_push = stage_valid && !cmd_full;

  // Unused opcodes are dropped here and never reach the queue
  assign op_known = operation inside {[OP_WRITE_ONE:OP_TICK]};

  // First half of the index reduction: quotient estimate
  assign recip_prod = 33'(led_index) * 33'(RECIP_MULT);

  // Second half: remainder from the registered quotient
  assign quot_scaled = 32'(stage_quot) * 32'(NUM_LEDS);
  assign led_rem     = stage_index - quot_scaled[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= op_known;
    end else if (cmd_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op    <= op_t'(operation);
      stage_index <= led_index;
      stage_quot  <= 16'(recip_prod >> RECIP_SHIFT);
      stage_red   <= red;
      stage_green <= green;
      stage_blue  <= blue;
    end
  end

  always_comb begin
    cmd_data.op    = stage_op;
    cmd_data.idx   = led_rem[IDX_W-1:0];
    cmd_data.red   = stage_red;
    cmd_data.green = stage_green;
    cmd_data.blue  = stage_blue;
  end

endmodule

`default_nettype wire

/* design/alfb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module alfb_queue import alfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == COUNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("command queue fill level out of range");

endmodule

`default_nettype wire

/* design/alfb_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module alfb_back import alfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  brightness_mult,
  input  logic [7:0]  brightness_div,
  input  logic [15:0] pwm_period,
  input  logic        cmd_empty,
  input  cmd_t        cmd_head,
  output logic        cmd_pop,
  output logic        result_valid,
  output logic        result_kind,
  output logic [7:0]  read_red,
  output logic [7:0]  read_green,
  output logic [7:0]  read_blue,
  output logic [15:0] compare_value,
  output logic        last_slot
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL     = 4'd1;
  localparam logic [3:0] ST_DIV     = 4'd2;
  localparam logic [3:0] ST_WRITE   = 4'd3;
  localparam logic [3:0] ST_RDOUT   = 4'd4;
  localparam logic [3:0] ST_LATCH   = 4'd5;
  localparam logic [3:0] ST_TICKOUT = 4'd6;

  localparam int LANES = 3;

  logic [3:0]        state;
  cmd_t              cmd;
  logic [2:0]        step;
  logic [CNT_W-1:0]  sweep;
  logic              pend;
  logic [IDX_W-1:0]  pend_addr;

  // Scaling lanes: 0 green, 1 red, 2 blue (store word order)
  logic [7:0]  lane_rem [LANES];
  logic [7:0]  lane_quo [LANES];
  logic        lane_sat [LANES];
  logic [7:0]  lane_in  [LANES];
  logic [15:0] lane_prod [LANES];
  logic [8:0]  lane_trial [LANES];
  logic        lane_ge [LANES];
  logic [7:0]  scaled [LANES];

  // Stores
  logic [23:0]          color_mem [NUM_LEDS];
  logic [23:0]          frame_mem [NUM_LEDS];
  logic [NUM_LEDS-1:0]  color_valid;
  logic                 frame_loaded;
  logic [23:0]          color_rd;
  logic                 color_rd_valid;
  logic [23:0]          frame_rd;
  logic                 color_we;
  logic [IDX_W-1:0]     color_waddr;
  logic [IDX_W-1:0]     color_raddr;
  logic [23:0]          color_wdata;

  // Frame sequencing
  logic              frame_active;
  logic [SLOT_W-1:0] slot_cnt;
  logic [IDX_W-1:0]  led_cnt;
  logic [4:0]        bit_cnt;
  logic              in_data;
  logic              bit_val;

  // Bit-slot compare words
  logic [15:0] one_val;
  logic [15:0] zero_val;

  assign cmd_pop = (state == ST_IDLE) && !cmd_empty;

  // Scaling datapath
  assign lane_in[0] = cmd.green;
  assign lane_in[1] = cmd.red;
  assign lane_in[2] = cmd.blue;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_prod[i]  = 16'(lane_in[i]) * 16'(brightness_mult);
      lane_trial[i] = {lane_rem[i], lane_quo[i][7]};
      lane_ge[i]    = (lane_trial[i] >= {1'b0, brightness_div});
      scaled[i]     = lane_sat[i] ? 8'hFF : lane_quo[i];
    end
  end

  // Color store ports
  assign color_we    = (state == ST_WRITE);
  assign color_waddr = (cmd.op == OP_WRITE_ALL) ? sweep[IDX_W-1:0] : cmd.idx;
  assign color_wdata = {scaled[0], scaled[1], scaled[2]};
  assign color_raddr = (state == ST_LATCH) ? sweep[IDX_W-1:0] : cmd_head.idx;

  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[color_waddr] <= color_wdata;
    end
    color_rd <= color_mem[color_raddr];
  end

  // Frame store: filled only by the latch sweep, read at the current LED
  always_ff @(posedge clk) begin
    if (pend) begin
      frame_mem[pend_addr] <= color_rd_valid ? color_rd : '0;
    end
    frame_rd <= frame_mem[led_cnt];
  end

  // Period thirds, kept current from the register
  always_ff @(posedge clk) begin
    one_val  <= 16'((33'({pwm_period, 1'b0}) * 33'(DIV3_MULT)) >> DIV3_SHIFT);
    zero_val <= 16'((33'(pwm_period) * 33'(DIV3_MULT)) >> DIV3_SHIFT);
  end

  // Slot decode
  assign in_data = (slot_cnt >= SLOT_W'(RESET_SLOTS)) && (slot_cnt < SLOT_W'(DATA_END));
  assign bit_val = frame_loaded && frame_rd[5'(BITS_PER_LED - 1) - bit_cnt];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pend           <= 1'b0;
      color_valid    <= '0;
      frame_loaded   <= 1'b0;
      frame_active   <= 1'b0;
      slot_cnt       <= '0;
      led_cnt        <= '0;
      bit_cnt        <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid   <= 1'b0;
      color_rd_valid <= color_valid[color_raddr];
      if (color_we) begin
        color_valid[color_waddr] <= 1'b1;
      end
      if (pend) begin
        frame_loaded <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd <= cmd_head;
            case (cmd_head.op)
              OP_WRITE_ONE, OP_WRITE_ALL: begin
                state <= ST_MUL;
              end
              OP_READ_ONE: begin
                state <= ST_RDOUT;
              end
              OP_LATCH: begin
                sweep <= '0;
                state <= ST_LATCH;
              end
              OP_START: begin
                frame_active <= 1'b1;
                slot_cnt     <= '0;
                led_cnt      <= '0;
                bit_cnt      <= '0;
              end
              OP_TICK: begin
                if (frame_active) begin
                  state <= ST_TICKOUT;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // products and saturation check
        ST_MUL: begin
          for (int i = 0; i < LANES; i++) begin
            lane_rem[i] <= lane_prod[i][15:8];
            lane_quo[i] <= lane_prod[i][7:0];
            lane_sat[i] <= (brightness_div == '0) || (lane_prod[i][15:8] >= brightness_div);
          end
          step  <= '0;
          state <= ST_DIV;
        end

        // restoring division, one quotient bit per cycle
        ST_DIV: begin
          for (int i = 0; i < LANES; i++) begin
            lane_rem[i] <= lane_ge[i] ? 8'(lane_trial[i] - {1'b0, brightness_div})
                                      : lane_trial[i][7:0];
            lane_quo[i] <= {lane_quo[i][6:0], lane_ge[i]};
          end
          step <= step + 1'b1;
          if (step == 3'd7) begin
            sweep <= '0;
            state <= ST_WRITE;
          end
        end

        ST_WRITE: begin
          sweep <= sweep + 1'b1;
          if (cmd.op != OP_WRITE_ALL || sweep[IDX_W-1:0] == IDX_W'(NUM_LEDS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_RDOUT: begin
          result_valid  <= 1'b1;
          result_kind   <= 1'b0;
          read_red      <= color_rd_valid ? color_rd[15:8] : '0;
          read_green    <= color_rd_valid ? color_rd[23:16] : '0;
          read_blue     <= color_rd_valid ? color_rd[7:0] : '0;
          compare_value <= '0;
          last_slot     <= 1'b0;
          state         <= ST_IDLE;
        end

        // read one entry a cycle, write its registered read data to the frame store
        ST_LATCH: begin
          if (sweep != CNT_W'(NUM_LEDS)) begin
            sweep     <= sweep + 1'b1;
            pend      <= 1'b1;
            pend_addr <= sweep[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_IDLE;
            end
          end
        end

        ST_TICKOUT: begin
          result_valid  <= 1'b1;
          result_kind   <= 1'b1;
          read_red      <= '0;
          read_green    <= '0;
          read_blue     <= '0;
          compare_value <= in_data ? (bit_val ? one_val : zero_val) : '0;
          if (slot_cnt == SLOT_W'(TOTAL_SLOTS - 1)) begin
            last_slot    <= 1'b1;
            frame_active <= 1'b0;
            slot_cnt     <= '0;
            led_cnt      <= '0;
            bit_cnt      <= '0;
          end else begin
            last_slot <= 1'b0;
            slot_cnt  <= slot_cnt + 1'b1;
            if (in_data) begin
              if (bit_cnt == 5'(BITS_PER_LED - 1)) begin
                bit_cnt <= '0;
                led_cnt <= led_cnt + 1'b1;
              end else begin
                bit_cnt <= bit_cnt + 1'b1;
              end
            end
          end
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_RDOUT || $past(state) == ST_TICKOUT))
    else $error("result strobe without a read or tick");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind && last_slot) |-> !frame_active)
    else $error("frame still active after its last slot");

  a_tick_needs_frame: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICKOUT) |-> frame_active)
    else $error("slot produced with no frame armed");

endmodule

`default_nettype wire

/* design/addressable_led_frame_builder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Addressable LED frame builder. Commands are taken on start while busy is low;
// results come out as a one-cycle result_valid beat that the receiver cannot
// stall, so it must take every beat. Commands run one at a time in order
// behind a two-entry queue. Work per command, set by the back-end sequencer:
// tick and read-one do one frame store or color store read, write-one runs
// an 8-step divider per channel, write-all does that and then one store
// write per cycle, latch copies one entry per cycle into the frame store.
// The front end registers each command for index reduction.
// Stores read as zero until written; no clearing pass after reset.
module addressable_led_frame_builder_core import alfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        result_valid,
  output logic        result_kind,
  output logic [7:0]  read_red,
  output logic [7:0]  read_green,
  output logic [7:0]  read_blue,
  output logic [15:0] compare_value,
  output logic        last_slot,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_MULT   = 2'd0;
  localparam logic [1:0] REG_DIV    = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  logic [7:0]  brightness_mult;
  logic [7:0]  brightness_div;
  logic [15:0] pwm_period;
  logic        reg_write;

  logic cmd_push;
  cmd_t cmd_data;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_head;
  logic cmd_empty;

  // Register file
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_mult <= MULT_RESET;
      brightness_div  <= DIV_RESET;
      pwm_period      <= PERIOD_RESET;
    end else if (reg_write) begin
      case (paddr[3:2])
        REG_MULT:   brightness_mult <= pwdata[7:0];
        REG_DIV:    brightness_div  <= pwdata[7:0];
        REG_PERIOD: pwm_period      <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MULT:   prdata = {24'd0, brightness_mult};
      REG_DIV:    prdata = {24'd0, brightness_div};
      REG_PERIOD: prdata = {16'd0, pwm_period};
      default:    prdata = '0;
    endcase
  end

  alfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data),
    .cmd_full  (cmd_full)
  );

  alfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  alfb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .brightness_mult (brightness_mult),
    .brightness_div  (brightness_div),
    .pwm_period      (pwm_period),
    .cmd_empty       (cmd_empty),
    .cmd_head        (cmd_head),
    .cmd_pop         (cmd_pop),
    .result_valid    (result_valid),
    .result_kind     (result_kind),
    .read_red        (read_red),
    .read_green      (read_green),
    .read_blue       (read_blue),
    .compare_value   (compare_value),
    .last_slot       (last_slot)
  );

endmodule

`default_nettype wire

/* tb/sv/addressable_led_frame_builder_core_tb.sv */
`timescale 1ns / 1ps

module addressable_led_frame_builder_core_tb;
  import alfb_pkg::*;

  // Register byte addresses
  localparam logic [3:0] ADDR_MULT   = 4'd0;
  localparam logic [3:0] ADDR_DIV    = 4'd4;
  localparam logic [3:0] ADDR_PERIOD = 4'd8;

  localparam int SETTLE_CYCLES = 400;   // four write-alls in flight, with margin
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int MIXED_ITEMS   = 30;

  // One result beat as seen on the result ports
  typedef struct packed {
    logic        kind;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] cmp;
    logic        last;
  } led_beat_t;

  // Mirror of the LED store and frame sequencer; holds the beats still due
  class led_frame_predictor;
    logic [7:0]  mult;
    logic [7:0]  div;
    logic [15:0] period;
    logic [23:0] colors [NUM_LEDS];   // {r, g, b}
    logic [23:0] frame  [NUM_LEDS];
    int unsigned slot;
    bit          active;
    led_beat_t   expected_beats [$];
    int          errors;

    function new();
      mult   = MULT_RESET;
      div    = DIV_RESET;
      period = PERIOD_RESET;
      foreach (colors[i]) begin
        colors[i] = '0;
        frame[i]  = '0;
      end
      slot   = 0;
      active = 0;
      errors = 0;
    endfunction

    function void write_register(logic [3:0] addr, logic [31:0] data);
      case (addr)
        ADDR_MULT:   mult   = data[7:0];
        ADDR_DIV:    div    = data[7:0];
        ADDR_PERIOD: period = data[15:0];
        default: ;
      endcase
    endfunction

    // Brightness scaling with saturation; zero divisor pins the channel high
    function logic [7:0] scale(logic [7:0] v);
      int unsigned q;
      if (div == 8'd0) return 8'hFF;
      q = v;
      q = q * mult;
      q = q / div;
      return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    function logic [15:0] slot_word(int unsigned s);
      int unsigned d;
      int unsigned led;
      int unsigned pos;
      int unsigned w;
      logic [7:0]  chan;
      if (s < RESET_SLOTS) return 16'd0;
      d = s - RESET_SLOTS;
      if (d >= BITS_PER_LED * NUM_LEDS) return 16'd0;
      led = d / BITS_PER_LED;
      pos = d % BITS_PER_LED;
      // wire order is green, red, blue
      if (pos < 8) chan = frame[led][15:8];
      else if (pos < 16) chan = frame[led][23:16];
      else chan = frame[led][7:0];
      w = period;
      if (chan[7 - pos % 8]) w = (2 * w) / 3;
      else w = w / 3;
      return w[15:0];
    endfunction

    function void note_command(logic [2:0] op, logic [15:0] idx,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned led;
      led_beat_t   beat;
      led  = idx;
      led  = led % NUM_LEDS;
      beat = '0;
      case (op)
        OP_WRITE_ONE: colors[led] = {scale(r), scale(g), scale(b)};
        OP_WRITE_ALL: begin
          foreach (colors[i]) colors[i] = {scale(r), scale(g), scale(b)};
        end
        OP_READ_ONE: begin
          {beat.r, beat.g, beat.b} = colors[led];
          expected_beats.push_back(beat);
        end
        OP_LATCH: begin
          foreach (frame[i]) frame[i] = colors[i];
        end
        OP_START: begin
          active = 1;
          slot   = 0;
        end
        OP_TICK: begin
          // ignored while no frame is running
          if (active) begin
            beat.kind = 1'b1;
            beat.cmp  = slot_word(slot);
            if (slot + 1 >= TOTAL_SLOTS) begin
              beat.last = 1'b1;
              active    = 0;
              slot      = 0;
            end else begin
              slot++;
            end
            expected_beats.push_back(beat);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_beat(led_beat_t got);
      led_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat: kind=%0d rgb=%02h%02h%02h cmp=%0d last=%0d",
                         got.kind, got.r, got.g, got.b, got.cmp, got.last));
        return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind || got.r !== want.r || got.g !== want.g ||
          got.b !== want.b || got.cmp !== want.cmp || got.last !== want.last)
        report($sformatf({"beat mismatch: expected kind=%0d rgb=%02h%02h%02h cmp=%0d last=%0d",
                          ", got kind=%0d rgb=%02h%02h%02h cmp=%0d last=%0d"},
                         want.kind, want.r, want.g, want.b, want.cmp, want.last,
                         got.kind, got.r, got.g, got.b, got.cmp, got.last));
    endfunction

    function void check_drained();
      if (expected_beats.size() != 0)
        report($sformatf("%0d expected beats never arrived", expected_beats.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [15:0] led_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        result_valid;
  logic        result_kind;
  logic [7:0]  read_red;
  logic [7:0]  read_green;
  logic [7:0]  read_blue;
  logic [15:0] compare_value;
  logic        last_slot;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  led_frame_predictor frame_model = new();
  bit no_gaps = 1'b0;
  int stall_cycles = 0;

  always #6 clk = ~clk;

  addressable_led_frame_builder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .led_index     (led_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .read_red      (read_red),
    .read_green    (read_green),
    .read_blue     (read_blue),
    .compare_value (compare_value),
    .last_slot     (last_slot),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Result monitor: every strobe is a beat
  always @(posedge clk) begin : beat_monitor
    led_beat_t got;
    if (!rst && result_valid) begin
      got.kind = result_kind;
      got.r    = read_red;
      got.g    = read_green;
      got.b    = read_blue;
      got.cmp  = compare_value;
      got.last = last_slot;
      frame_model.check_beat(got);
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // One command beat; optional idle gap first
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!no_gaps && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    led_index <= idx;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (busy);
    frame_model.note_command(op, idx, r, g, b);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_model.write_register(addr, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] m, input logic [7:0] d, input logic [15:0] p);
    apb_write(ADDR_MULT, {24'd0, m});
    apb_write(ADDR_DIV, {24'd0, d});
    apb_write(ADDR_PERIOD, {16'd0, p});
  endtask

  // Drain outstanding beats and let silent commands finish
  task automatic settle();
    start <= 1'b0;
    while (frame_model.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_cmd(input bit allow_start);
    int          pick;
    logic [2:0]  op;
    logic [15:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 18) op = OP_WRITE_ONE;
    else if (pick < 21) op = OP_WRITE_ALL;
    else if (pick < 39) op = OP_READ_ONE;
    else if (pick < 44) op = OP_LATCH;
    else if (pick < 48) op = allow_start ? OP_START : OP_TICK;
    else if (pick < 96) op = OP_TICK;
    else op = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 3) == 0) idx = 16'($urandom_range(0, NUM_LEDS - 1));
    else idx = 16'($urandom_range(0, 65535));
    send_cmd(op, idx, rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic mixed_phase(input logic [7:0] m, input logic [7:0] d, input logic [15:0] p);
    configure(m, d, p);
    repeat (MIXED_ITEMS) random_cmd(1'b1);
    settle();
  endtask

  initial begin : stimulus
    int n;
    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= '0;
    led_index <= '0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, index wrap, ignored items, restart, latch mid-frame
    send_cmd(OP_READ_ONE, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_WRITE_ONE, 16'd0, 8'hFF, 8'h00, 8'h80);
    send_cmd(OP_WRITE_ONE, 16'hFFFF, 8'h00, 8'hFF, 8'h01);
    send_cmd(OP_READ_ONE, 16'd64, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ_ONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_TICK, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(3'd6, 16'h5555, 8'h55, 8'h55, 8'h55);
    send_cmd(3'd7, 16'hAAAA, 8'hAA, 8'hAA, 8'hAA);
    send_cmd(OP_LATCH, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_START, 16'd0, 8'h00, 8'h00, 8'h00);
    repeat (3) send_cmd(OP_TICK, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_START, 16'd0, 8'h00, 8'h00, 8'h00);
    repeat (RESET_SLOTS + 1) send_cmd(OP_TICK, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_WRITE_ALL, 16'd3, 8'hAA, 8'h55, 8'h0F);
    send_cmd(OP_LATCH, 16'd0, 8'h00, 8'h00, 8'h00);
    repeat (4) send_cmd(OP_TICK, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ_ONE, 16'd37, 8'h00, 8'h00, 8'h00);
    settle();

    // Random phases across register extremes
    mixed_phase(8'd255, 8'd1, 16'd65535);
    mixed_phase(8'd0, 8'd0, 16'd1);
    mixed_phase(8'd3, 8'd2, 16'd0);

    // One full frame end to end, no restarts
    configure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              16'($urandom_range(1, 65535)));
    send_cmd(OP_START, 16'($urandom_range(0, 65535)), rand_channel(), rand_channel(),
             rand_channel());
    n = 0;
    while (frame_model.active) begin
      no_gaps = (n >= 400 && n < 900);
      if ($urandom_range(0, 9) != 0)
        send_cmd(OP_TICK, 16'($urandom_range(0, 65535)), rand_channel(), rand_channel(),
                 rand_channel());
      else
        random_cmd(1'b0);
      n++;
    end
    no_gaps = 1'b0;
    settle();

    mixed_phase(8'd0, 8'd200, 16'd2);
    mixed_phase(8'd1, 8'd255, 16'd104);

    frame_model.check_drained();
    if (frame_model.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
